// ----- hw/rtl/salc_pkg.sv -----
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants of the LRU cache tag-store model
// Defaults for the module parameters, register indexes, access codes and the
// recency rank format.
// ----------------------------------------------------------------------------
package salc_pkg;

   localparam int DEF_MAX_SET_BITS = 8;
   localparam int DEF_MAX_WAYS     = 8;
   localparam int DEF_ADDR_WIDTH   = 32;

   // recency rank, 0 = most recent, saturates at RANK_MAX
   localparam int RANK_W    = 3;
   localparam int RANK_MAX  = 7;
   localparam int COUNT_W   = 32;

   typedef logic [RANK_W-1:0] rank_type;
   typedef logic [COUNT_W-1:0] count_type;

   // access kinds
   localparam int OP_W = 2;
   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_LOAD   = 2'd0;
   localparam op_type OP_STORE  = 2'd1;
   localparam op_type OP_MODIFY = 2'd2;
   localparam op_type OP_NONE   = 2'd3;

   // configuration registers
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_SET_BITS   = 2'd0;
   localparam csr_idx_type CSR_BLOCK_BITS = 2'd1;
   localparam csr_idx_type CSR_WAYS       = 2'd2;

   localparam int SET_BITS_W   = 4;
   localparam int BLOCK_BITS_W = 5;
   localparam int WAYS_W       = 4;
   localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 4'd4;
   localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;
   localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

endpackage

// ----- hw/rtl/set_assoc_lru_cache_sim.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim: set-associative tag store with LRU replacement
// Counts hits, misses and evictions for a stream of load/store/modify items.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: req_op and req_address, taken when req_valid is high and
//   req_stall is low. rsp channel: one result item per request with the hit
//   and eviction flags and the three running totals, taken when rsp_valid is
//   high and rsp_stall is low. csr_we/csr_index/csr_wdata write set_bits,
//   block_bits and ways_in_use; write them only while the block is idle.
//   Each set is one row of the tag memory. An item reads its row, then one
//   shared tag comparator walks the ways one per cycle, then the row is aged
//   and written back. A load or store passes the read, load, scan, touch,
//   write and done states before its result is valid; a modify runs the way
//   walk and the update twice, and an unused op goes straight to done.
//   The way walk sets the rate; one item is in flight at a time.
//   Reset clears the registers and totals, then a clearing pass writes every
//   row of the memory, one row per cycle, 2^MAX_SET_BITS rows (256 by
//   default); req_stall stays high until it ends. A stalled result is held
//   in the output register; the next item may be accepted meanwhile but its
//   result waits until the held one is taken.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim #(
   parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
   parameter int ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  salc_pkg::op_type                 req_op,
   input  logic [ADDR_WIDTH-1:0]            req_address,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_first_hit,
   output logic                             rsp_evicted,
   output logic                             rsp_second_hit,
   output salc_pkg::count_type              rsp_hit_total,
   output salc_pkg::count_type              rsp_miss_total,
   output salc_pkg::count_type              rsp_eviction_total,
   input  logic                             csr_we,
   input  salc_pkg::csr_idx_type            csr_index,
   input  logic [salc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SETS      = 1 << MAX_SET_BITS;
   localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
   localparam int SHIFT_W   = $clog2(MAX_SET_BITS + 32 + ADDR_WIDTH + 1);
   localparam int LANE_W    = 1 + ADDR_WIDTH + salc_pkg::RANK_W;
   localparam int ROW_W     = MAX_WAYS * LANE_W;
   localparam int OLD_W     = salc_pkg::RANK_W + 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_TOUCH = 3'd5;
   localparam logic [2:0] ST_WRITE = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   // configuration
   logic [salc_pkg::SET_BITS_W-1:0]   set_bits_ff;
   logic [salc_pkg::BLOCK_BITS_W-1:0] block_bits_ff;
   logic [salc_pkg::WAYS_W-1:0]       ways_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= salc_pkg::SET_BITS_RST;
         block_bits_ff <= salc_pkg::BLOCK_BITS_RST;
         ways_ff       <= salc_pkg::WAYS_RST;
      end else if (csr_we) begin
         case (csr_index)
            salc_pkg::CSR_SET_BITS:   set_bits_ff   <= csr_wdata[salc_pkg::SET_BITS_W-1:0];
            salc_pkg::CSR_BLOCK_BITS: block_bits_ff <= csr_wdata;
            salc_pkg::CSR_WAYS:       ways_ff       <= csr_wdata[salc_pkg::WAYS_W-1:0];
            default: ;
         endcase
      end
   end

   // effective geometry
   logic [salc_pkg::SET_BITS_W-1:0] sb_eff;
   logic [WAY_CNT_W-1:0]            ways_eff;
   logic [SHIFT_W-1:0]              shift_total;
   logic [SET_IDX_W:0]              set_mask;
   logic [ADDR_WIDTH-1:0]           set_shifted;
   logic [SET_IDX_W-1:0]            set_in;
   logic [ADDR_WIDTH-1:0]           tag_in;

   always_comb begin
      if (set_bits_ff > salc_pkg::SET_BITS_W'(MAX_SET_BITS))
         sb_eff = salc_pkg::SET_BITS_W'(MAX_SET_BITS);
      else
         sb_eff = set_bits_ff;
      if (ways_ff == '0)
         ways_eff = WAY_CNT_W'(1);
      else if ({1'b0, ways_ff} > 5'(MAX_WAYS))
         ways_eff = WAY_CNT_W'(MAX_WAYS);
      else
         ways_eff = WAY_CNT_W'(ways_ff);
      shift_total = SHIFT_W'(sb_eff) + SHIFT_W'(block_bits_ff);
      set_mask    = ((SET_IDX_W + 1)'(1) << sb_eff) - (SET_IDX_W + 1)'(1);
      set_shifted = req_address >> block_bits_ff;
      set_in      = set_shifted[SET_IDX_W-1:0] & set_mask[SET_IDX_W-1:0];
      if (shift_total >= SHIFT_W'(ADDR_WIDTH))
         tag_in = '0;
      else
         tag_in = req_address >> shift_total;
   end

   // sequencer state
   logic [2:0]              state_ff, state_in;
   logic [SET_IDX_W-1:0]    clr_ff, clr_in;
   logic [SET_IDX_W-1:0]    set_ff, set_in_q;
   logic [ADDR_WIDTH-1:0]   tag_ff, tag_in_q;
   logic                    modify_ff, modify_in;
   logic                    pass_ff, pass_in;
   logic [WAY_W-1:0]        way_ff, way_in;
   logic                    hit_found_ff, hit_found_in;
   logic [WAY_W-1:0]        hit_way_ff, hit_way_in;
   logic                    inv_found_ff, inv_found_in;
   logic [WAY_W-1:0]        inv_way_ff, inv_way_in;
   salc_pkg::rank_type      top_ff, top_in;
   logic [WAY_W-1:0]        victim_ff, victim_in;
   logic                    first_hit_ff, first_hit_in;
   logic                    evict_ff, evict_in;
   logic                    second_hit_ff, second_hit_in;
   salc_pkg::count_type     hits_ff, hits_in;
   salc_pkg::count_type     misses_ff, misses_in;
   salc_pkg::count_type     evicts_ff, evicts_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_first_ff, out_evict_ff, out_second_ff;
   salc_pkg::count_type     out_hits_ff, out_misses_ff, out_evicts_ff;
   logic                    out_load;

   // working row
   logic                    row_valid_ff [MAX_WAYS];
   logic [ADDR_WIDTH-1:0]   row_tag_ff   [MAX_WAYS];
   salc_pkg::rank_type      row_rank_ff  [MAX_WAYS];
   logic                    touch_valid  [MAX_WAYS];
   logic [ADDR_WIDTH-1:0]   touch_tag    [MAX_WAYS];
   salc_pkg::rank_type      touch_rank   [MAX_WAYS];

   // tag memory, one row per set
   logic [ROW_W-1:0]        mem [SETS];
   logic [ROW_W-1:0]        rd_row_ff;
   logic [ROW_W-1:0]        wr_row;
   logic                    mem_we;
   logic [SET_IDX_W-1:0]    mem_waddr;

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_waddr] <= wr_row;
      if (state_ff == ST_READ)
         rd_row_ff <= mem[set_ff];
   end

   always_comb begin
      mem_we    = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
      mem_waddr = (state_ff == ST_CLEAR) ? clr_ff : set_ff;
      wr_row    = '0;
      if (state_ff == ST_WRITE) begin
         for (int w = 0; w < MAX_WAYS; w++)
            wr_row[w*LANE_W +: LANE_W] = {row_valid_ff[w], row_tag_ff[w], row_rank_ff[w]};
      end
   end

   // shared per-way unit: one tag compare and one rank compare per cycle
   logic                    lane_valid;
   logic                    lane_match;
   logic                    scan_last;
   logic [WAY_W-1:0]        chosen;
   logic                    chosen_hit;
   logic [OLD_W-1:0]        old_rank;

   always_comb begin
      lane_valid = row_valid_ff[way_ff];
      lane_match = lane_valid && (row_tag_ff[way_ff] == tag_ff);
      scan_last  = (way_ff == WAY_W'(ways_eff - WAY_CNT_W'(1)));
      chosen_hit = hit_found_ff;
      if (hit_found_ff)
         chosen = hit_way_ff;
      else if (inv_found_ff)
         chosen = inv_way_ff;
      else
         chosen = victim_ff;
      old_rank = row_valid_ff[chosen] ? {1'b0, row_rank_ff[chosen]}
                                      : OLD_W'(salc_pkg::RANK_MAX + 1);
   end

   // move the chosen way to the front; younger valid lines age by one, saturating at RANK_MAX
   always_comb begin
      for (int v = 0; v < MAX_WAYS; v++) begin
         touch_valid[v] = row_valid_ff[v];
         touch_tag[v]   = row_tag_ff[v];
         touch_rank[v]  = row_rank_ff[v];
         if (WAY_W'(v) == chosen) begin
            touch_rank[v] = '0;
            if (!chosen_hit) begin
               touch_valid[v] = 1'b1;
               touch_tag[v]   = tag_ff;
            end
         end else if ((WAY_CNT_W'(v) < ways_eff) && row_valid_ff[v]
                      && ({1'b0, row_rank_ff[v]} < old_rank)
                      && (row_rank_ff[v] != salc_pkg::RANK_W'(salc_pkg::RANK_MAX))) begin
            touch_rank[v] = row_rank_ff[v] + salc_pkg::RANK_W'(1);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      set_in_q      = set_ff;
      tag_in_q      = tag_ff;
      modify_in     = modify_ff;
      pass_in       = pass_ff;
      way_in        = way_ff;
      hit_found_in  = hit_found_ff;
      hit_way_in    = hit_way_ff;
      inv_found_in  = inv_found_ff;
      inv_way_in    = inv_way_ff;
      top_in        = top_ff;
      victim_in     = victim_ff;
      first_hit_in  = first_hit_ff;
      evict_in      = evict_ff;
      second_hit_in = second_hit_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      evicts_in     = evicts_ff;
      out_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SET_IDX_W'(1);
            if (clr_ff == SET_IDX_W'(SETS - 1))
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               set_in_q      = set_in;
               tag_in_q      = tag_in;
               modify_in     = (req_op == salc_pkg::OP_MODIFY);
               pass_in       = 1'b0;
               first_hit_in  = 1'b0;
               evict_in      = 1'b0;
               second_hit_in = 1'b0;
               state_in      = (req_op == salc_pkg::OP_NONE) ? ST_DONE : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            way_in       = '0;
            hit_found_in = 1'b0;
            inv_found_in = 1'b0;
            top_in       = '0;
            victim_in    = '0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (!hit_found_ff && lane_match) begin
               hit_found_in = 1'b1;
               hit_way_in   = way_ff;
            end
            if (!inv_found_ff && !lane_valid) begin
               inv_found_in = 1'b1;
               inv_way_in   = way_ff;
            end
            if (row_rank_ff[way_ff] > top_ff) begin
               top_in    = row_rank_ff[way_ff];
               victim_in = way_ff;
            end
            way_in = way_ff + WAY_W'(1);
            if (scan_last)
               state_in = ST_TOUCH;
         end
         ST_TOUCH: begin
            if (hit_found_ff) begin
               hits_in = hits_ff + salc_pkg::COUNT_W'(1);
            end else begin
               misses_in = misses_ff + salc_pkg::COUNT_W'(1);
               if (!inv_found_ff) begin
                  evicts_in = evicts_ff + salc_pkg::COUNT_W'(1);
                  evict_in  = 1'b1;
               end
            end
            if (pass_ff)
               second_hit_in = hit_found_ff;
            else
               first_hit_in = hit_found_ff;
            // run the access again on the updated row for a modify
            way_in       = '0;
            hit_found_in = 1'b0;
            inv_found_in = 1'b0;
            top_in       = '0;
            victim_in    = '0;
            if (modify_ff && !pass_ff) begin
               pass_in  = 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the previous result is taken
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         pass_ff      <= 1'b0;
         modify_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evicts_ff    <= evicts_in;
         pass_ff      <= pass_in;
         modify_ff    <= modify_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff        <= set_in_q;
      tag_ff        <= tag_in_q;
      way_ff        <= way_in;
      hit_found_ff  <= hit_found_in;
      hit_way_ff    <= hit_way_in;
      inv_found_ff  <= inv_found_in;
      inv_way_ff    <= inv_way_in;
      top_ff        <= top_in;
      victim_ff     <= victim_in;
      first_hit_ff  <= first_hit_in;
      evict_ff      <= evict_in;
      second_hit_ff <= second_hit_in;
      if (out_load) begin
         out_first_ff  <= first_hit_ff;
         out_evict_ff  <= evict_ff;
         out_second_ff <= second_hit_ff;
         out_hits_ff   <= hits_ff;
         out_misses_ff <= misses_ff;
         out_evicts_ff <= evicts_ff;
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (state_ff == ST_LOAD) begin
            {row_valid_ff[w], row_tag_ff[w], row_rank_ff[w]} <= rd_row_ff[w*LANE_W +: LANE_W];
         end else if (state_ff == ST_TOUCH) begin
            row_valid_ff[w] <= touch_valid[w];
            row_tag_ff[w]   <= touch_tag[w];
            row_rank_ff[w]  <= touch_rank[w];
         end
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_first_hit      = out_first_ff;
   assign rsp_evicted        = out_evict_ff;
   assign rsp_second_hit     = out_second_ff;
   assign rsp_hit_total      = out_hits_ff;
   assign rsp_miss_total     = out_misses_ff;
   assign rsp_eviction_total = out_evicts_ff;

endmodule
